### design/crlf_line_assembler_trim_assert.svh
// assertion macros shared by the line assembler rtl
// depends on nothing; the asserting module must provide clk and arst_n
`ifndef CRLF_LINE_ASSEMBLER_TRIM_ASSERT_SVH
`define CRLF_LINE_ASSEMBLER_TRIM_ASSERT_SVH
`ifndef SYNTHESIS
// property checked on every rising edge outside reset
`define CLAT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("line assembler check failed");
// same, with a caller supplied message
`define CLAT_ASSERT_MSG(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);
`else
`define CLAT_ASSERT(lbl, prop)
`define CLAT_ASSERT_MSG(lbl, prop, msg)
`endif
`endif

### design/clat_pkg.sv
// shared types and constants of the crlf line assembler
// no dependencies
package clat_pkg;

	// default line store depth
	localparam int LINE_MAX_DEF = 64;

	// one stored byte
	typedef logic [7:0] char_t;

	// byte codes with a special meaning
	localparam char_t CH_CR    = 8'd13;
	localparam char_t CH_LF    = 8'd10;
	localparam char_t CH_SPACE = 8'd32;
	localparam char_t CH_TAB   = 8'd9;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SHOW
	} state_t;

endpackage

### design/clat_store.sv
// line store: single write port, single registered read port
// depends on clat_pkg
module clat_store #(
	parameter int DEPTH  = clat_pkg::LINE_MAX_DEF,
	parameter int ADDR_W = $clog2(clat_pkg::LINE_MAX_DEF)
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [ADDR_W-1:0]   wr_addr,
	input  clat_pkg::char_t     wr_data,
	input  logic                rd_en,
	input  logic [ADDR_W-1:0]   rd_addr,
	output clat_pkg::char_t     rd_data
);
	import clat_pkg::*;

	char_t mem [DEPTH];
	char_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### design/crlf_line_assembler_trim.sv
// Line assembler for a received byte stream. Bytes come in on the in_ word
// channel; CR, LF or a CR LF pair ends a line, trailing spaces and tabs are
// trimmed, and a non-empty line leaves on the out_ channel one byte per word
// with line_last on its final byte, while blank lines are dropped. A line may
// hold LINE_MAX-1 bytes; one more ordinary byte throws the whole line away
// together with that byte. A terminator that yields N bytes holds in_ready low
// for the emission: each byte is fetched through the store's registered read
// port in ST_READ and then presented in ST_SHOW until out_ready takes it, all
// under one index counter.
// Depends on clat_pkg, clat_store and crlf_line_assembler_trim_assert.svh.
`include "crlf_line_assembler_trim_assert.svh"

module crlf_line_assembler_trim #(
	parameter int LINE_MAX = clat_pkg::LINE_MAX_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  clat_pkg::char_t in_byte,
	output logic            out_valid,
	input  logic            out_ready,
	output clat_pkg::char_t line_char,
	output logic            line_last
);
	import clat_pkg::*;

	localparam int CNT_W = $clog2(LINE_MAX);
	localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(LINE_MAX - 1);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] nonblank_q;
	logic [CNT_W-1:0] len_q;
	logic [CNT_W-1:0] idx_q;
	logic             cr_seen_q;

	logic in_acc, out_acc;
	logic is_cr, is_lf, is_blank, ends_line, is_store, has_room, emit_line;
	logic last_byte;
	char_t rd_data;

	// byte decode
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;
	assign is_cr     = (in_byte == CH_CR);
	assign is_lf     = (in_byte == CH_LF);
	assign is_blank  = (in_byte == CH_SPACE) || (in_byte == CH_TAB);
	assign ends_line = is_cr || (is_lf && !cr_seen_q);
	assign is_store  = !is_cr && !is_lf;
	assign has_room  = (fill_q < FILL_MAX);
	assign emit_line = in_acc && ends_line && (nonblank_q != '0);
	assign last_byte = (idx_q == len_q - CNT_ONE);

	// next state and handshake outputs
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && ends_line && (nonblank_q != '0)) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_SHOW;
			end
			ST_SHOW: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = last_byte ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// fill tracking and terminator handling
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			nonblank_q <= '0;
			cr_seen_q  <= 1'b0;
		end else if (in_acc) begin
			cr_seen_q <= is_cr;
			if (ends_line || !has_room) begin
				if (is_store || ends_line) begin
					fill_q     <= '0;
					nonblank_q <= '0;
				end
			end else if (is_store) begin
				fill_q <= fill_q + CNT_ONE;
				if (!is_blank) begin
					nonblank_q <= fill_q + CNT_ONE;
				end
			end
		end
	end

	// emission index and length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			len_q <= '0;
		end else if (emit_line) begin
			idx_q <= '0;
			len_q <= nonblank_q;
		end else if (out_acc && !last_byte) begin
			idx_q <= idx_q + CNT_ONE;
		end
	end

	clat_store #(
		.DEPTH  (LINE_MAX),
		.ADDR_W (CNT_W)
	) u_store (
		.clk     (clk),
		.wr_en   (in_acc && is_store && has_room),
		.wr_addr (fill_q),
		.wr_data (in_byte),
		.rd_en   (state_q == ST_READ),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	assign line_char = rd_data;
	assign line_last = last_byte;

	// consistency checks
	`CLAT_ASSERT(a_fill_bound, (fill_q <= FILL_MAX) && (nonblank_q <= fill_q))
	`CLAT_ASSERT(a_idx_bound, (state_q != ST_IDLE) |-> (idx_q < len_q))
	`CLAT_ASSERT_MSG(a_start_emit, emit_line |=> (state_q == ST_READ) && (idx_q == '0),
		"line end did not start emission")
	`CLAT_ASSERT_MSG(a_end_emit, (out_acc && line_last) |=> in_ready && (fill_q == '0),
		"line emission did not return to idle")

endmodule
